>>> rtl/tmb_pkg.sv
package tmb_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned DataW       = 32;
  localparam int unsigned ProdW       = 2 * DataW;

  typedef enum logic [2:0] {
    OpIdentity  = 3'd0,
    OpTranslate = 3'd1,
    OpScale     = 3'd2,
    OpRotX      = 3'd3,
    OpRotY      = 3'd4,
    OpRotZ      = 3'd5,
    OpVertex    = 3'd6,
    OpWrite     = 3'd7
  } tmb_op_e;

  typedef struct packed {
    tmb_op_e                   op;
    logic signed [DataW-1:0]   arg_x;
    logic signed [DataW-1:0]   arg_y;
    logic signed [DataW-1:0]   arg_z;
    logic signed [DataW-1:0]   arg_w;
    logic        [3:0]         elem_index;
  } tmb_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] out_x;
    logic signed [DataW-1:0] out_y;
    logic signed [DataW-1:0] out_z;
    logic signed [DataW-1:0] out_w;
  } tmb_out_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [ProdW-1:0] v);
    logic hi_all1;
    logic hi_all0;
    hi_all1 = &v[ProdW-1:DataW-1];
    hi_all0 = ~|v[ProdW-1:DataW-1];
    if (hi_all1 || hi_all0) begin
      return v[DataW-1:0];
    end else if (v[ProdW-1]) begin
      return {1'b1, {(DataW-1){1'b0}}};
    end else begin
      return {1'b0, {(DataW-1){1'b1}}};
    end
  endfunction

endpackage

>>> rtl/transform_matrix_builder_core.sv
// Holds one 4x4 homogeneous transform in signed fixed point (FRAC_BITS fraction bits, Q16.16 by
// default), reset to identity, and applies one operation per item: identity, translate, scale,
// rotate about X/Y/Z from a supplied cosine (arg_x) and sine (arg_y), single-entry write, or
// matrix-times-vertex. An item is taken every cycle unless a vertex item waits on a stalled
// result; it is captured in the input register at its transfer, and from there sixteen 32x32
// lane multipliers with their adders and saturation update the matrix registers or load the
// result register, which offers a vertex result once its item leaves the input register. Only
// transform-vertex items produce a result; while a result stalls, matrix updates still advance,
// but the next vertex item waits in the input register and holds back every item behind it.
module transform_matrix_builder_core
  import tmb_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tmb_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output tmb_out_t out_data_o
);

  localparam logic [DataW-1:0] One = DataW'(1) << FRAC_BITS;

  logic                          in_valid_q;
  tmb_in_t                       in_q;
  logic                          out_valid_q;
  tmb_out_t                      out_q, out_d;
  logic [15:0][DataW-1:0]        mat_q, mat_d;

  logic                          is_vtx;
  logic                          out_free;
  logic                          s1_fire;

  logic signed [DataW-1:0]       mul_a [16];
  logic signed [DataW-1:0]       mul_b [16];
  logic signed [ProdW-1:0]       mul_p [16];
  logic signed [ProdW-1:0]       mul_q [16];
  logic signed [DataW-1:0]       rot_va [4];
  logic signed [DataW-1:0]       rot_vb [4];
  logic signed [DataW-1:0]       rot_a [4];
  logic signed [DataW-1:0]       rot_b [4];
  logic signed [DataW-1:0]       vtx [4];
  logic signed [DataW-1:0]       trn [3];

  assign is_vtx     = (in_q.op == OpVertex);
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = in_valid_q && (!is_vtx || out_free);
  assign in_ready_o = !in_valid_q || s1_fire;

  assign vtx[0] = in_q.arg_x;
  assign vtx[1] = in_q.arg_y;
  assign vtx[2] = in_q.arg_z;
  assign vtx[3] = in_q.arg_w;
  assign trn[0] = in_q.arg_x;
  assign trn[1] = in_q.arg_y;
  assign trn[2] = in_q.arg_z;

  // select the rotated row pair
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      unique case (in_q.op)
        OpRotX: begin
          rot_va[j] = $signed(mat_q[4+j]);
          rot_vb[j] = $signed(mat_q[8+j]);
        end
        OpRotY: begin
          rot_va[j] = $signed(mat_q[8+j]);
          rot_vb[j] = $signed(mat_q[j]);
        end
        default: begin
          rot_va[j] = $signed(mat_q[j]);
          rot_vb[j] = $signed(mat_q[4+j]);
        end
      endcase
    end
  end

  // lane operands
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      mul_a[i] = '0;
      mul_b[i] = '0;
    end
    unique case (in_q.op) inside
      OpTranslate: begin
        for (int r = 0; r < 3; r++) begin
          for (int j = 0; j < 4; j++) begin
            mul_a[4*r+j] = trn[r];
            mul_b[4*r+j] = $signed(mat_q[12+j]);
          end
        end
      end
      OpScale: begin
        for (int i = 0; i < 12; i++) begin
          mul_a[i] = in_q.arg_x;
          mul_b[i] = $signed(mat_q[i]);
        end
      end
      OpRotX, OpRotY, OpRotZ: begin
        for (int j = 0; j < 4; j++) begin
          mul_a[4*j+0] = in_q.arg_x;
          mul_b[4*j+0] = rot_va[j];
          mul_a[4*j+1] = in_q.arg_y;
          mul_b[4*j+1] = rot_vb[j];
          mul_a[4*j+2] = in_q.arg_y;
          mul_b[4*j+2] = rot_va[j];
          mul_a[4*j+3] = in_q.arg_x;
          mul_b[4*j+3] = rot_vb[j];
        end
      end
      OpVertex: begin
        for (int r = 0; r < 4; r++) begin
          for (int j = 0; j < 4; j++) begin
            mul_a[4*r+j] = vtx[j];
            mul_b[4*r+j] = $signed(mat_q[4*r+j]);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      mul_p[i] = $signed(ProdW'(mul_a[i])) * $signed(ProdW'(mul_b[i]));
      mul_q[i] = mul_p[i] >>> FRAC_BITS;
    end
    for (int j = 0; j < 4; j++) begin
      rot_a[j] = sat32(mul_q[4*j+0] - mul_q[4*j+1]);
      rot_b[j] = sat32(mul_q[4*j+2] + mul_q[4*j+3]);
    end
  end

  always_comb begin
    out_d.out_x = sat32(mul_q[0] + mul_q[1] + mul_q[2] + mul_q[3]);
    out_d.out_y = sat32(mul_q[4] + mul_q[5] + mul_q[6] + mul_q[7]);
    out_d.out_z = sat32(mul_q[8] + mul_q[9] + mul_q[10] + mul_q[11]);
    out_d.out_w = sat32(mul_q[12] + mul_q[13] + mul_q[14] + mul_q[15]);
  end

  // next matrix
  always_comb begin
    mat_d = mat_q;
    unique case (in_q.op)
      OpIdentity: begin
        mat_d = '0;
        for (int d = 0; d < 4; d++) begin
          mat_d[5*d] = One;
        end
      end
      OpTranslate: begin
        for (int i = 0; i < 12; i++) begin
          mat_d[i] = sat32($signed(ProdW'($signed(mat_q[i]))) + mul_q[i]);
        end
      end
      OpScale: begin
        for (int i = 0; i < 12; i++) begin
          mat_d[i] = sat32(mul_q[i]);
        end
      end
      OpRotX: begin
        for (int j = 0; j < 4; j++) begin
          mat_d[4+j] = rot_a[j];
          mat_d[8+j] = rot_b[j];
        end
      end
      OpRotY: begin
        for (int j = 0; j < 4; j++) begin
          mat_d[8+j] = rot_a[j];
          mat_d[j]   = rot_b[j];
        end
      end
      OpRotZ: begin
        for (int j = 0; j < 4; j++) begin
          mat_d[j]   = rot_a[j];
          mat_d[4+j] = rot_b[j];
        end
      end
      OpWrite: begin
        mat_d[in_q.elem_index] = in_q.arg_x;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        mat_q[i] <= (i % 5 == 0) ? One : '0;
      end
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (s1_fire) begin
        mat_q <= mat_d;
      end
      if (s1_fire && is_vtx) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (s1_fire && is_vtx) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_vtx_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && is_vtx |=> out_valid_q)
    else $error("vertex transfer did not raise a result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q && !(s1_fire && is_vtx) |=> !out_valid_q)
    else $error("result raised without a vertex transfer");

  a_hold_matrix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(mat_q))
    else $error("matrix changed without a transfer");

  a_row3_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && (in_q.op == OpTranslate || in_q.op == OpScale || in_q.op == OpRotX ||
                in_q.op == OpRotY || in_q.op == OpRotZ || in_q.op == OpVertex)
    |=> $stable(mat_q[15:12]))
    else $error("bottom row changed by an operation that keeps it");

  a_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && in_q.op == OpIdentity |=> mat_q[0] == One && mat_q[15] == One && mat_q[1] == '0)
    else $error("identity load failed");

endmodule

>>> test/transform_matrix_builder_core_checker.sv
module transform_matrix_builder_core_checker
  import tmb_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  tmb_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  tmb_out_t out_data_i,
  output int       mismatches_o,
  output int       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [DataW-1:0] mtx [16];
  tmb_out_t                vertex_q [$];
  int                      mismatches = 0;
  int                      pending = 0;

  assign mismatches_o = mismatches;
  assign pending_o    = pending;

  function automatic longint qmul(input logic signed [DataW-1:0] a,
                                  input logic signed [DataW-1:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> FRAC_BITS;
  endfunction

  function automatic logic signed [DataW-1:0] clamp32(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[DataW-1:0];
  endfunction

  function automatic void load_identity();
    for (int i = 0; i < 16; i++) begin
      mtx[i] = (i % 5 == 0) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
    end
  endfunction

  function automatic void rotate_rows(input int a, input int b,
                                      input logic signed [DataW-1:0] c,
                                      input logic signed [DataW-1:0] s);
    logic signed [DataW-1:0] va;
    logic signed [DataW-1:0] vb;
    for (int j = 0; j < 4; j++) begin
      va = mtx[a*4+j];
      vb = mtx[b*4+j];
      mtx[a*4+j] = clamp32(qmul(c, va) - qmul(s, vb));
      mtx[b*4+j] = clamp32(qmul(s, va) + qmul(c, vb));
    end
  endfunction

  function automatic void apply_op(input tmb_in_t it);
    logic signed [DataW-1:0] t [3];
    logic signed [DataW-1:0] v [4];
    longint acc;
    tmb_out_t res;
    t[0] = it.arg_x;
    t[1] = it.arg_y;
    t[2] = it.arg_z;
    case (it.op)
      OpIdentity: load_identity();
      OpTranslate: begin
        for (int r = 0; r < 3; r++) begin
          for (int j = 0; j < 4; j++) begin
            mtx[r*4+j] = clamp32(longint'(mtx[r*4+j]) + qmul(t[r], mtx[12+j]));
          end
        end
      end
      OpScale: begin
        for (int r = 0; r < 12; r++) begin
          mtx[r] = clamp32(qmul(it.arg_x, mtx[r]));
        end
      end
      OpRotX: rotate_rows(1, 2, it.arg_x, it.arg_y);
      OpRotY: rotate_rows(2, 0, it.arg_x, it.arg_y);
      OpRotZ: rotate_rows(0, 1, it.arg_x, it.arg_y);
      OpVertex: begin
        for (int r = 0; r < 4; r++) begin
          acc = qmul(it.arg_x, mtx[r*4+0]) + qmul(it.arg_y, mtx[r*4+1])
              + qmul(it.arg_z, mtx[r*4+2]) + qmul(it.arg_w, mtx[r*4+3]);
          v[r] = clamp32(acc);
        end
        res.out_x = v[0];
        res.out_y = v[1];
        res.out_z = v[2];
        res.out_w = v[3];
        vertex_q.push_back(res);
      end
      OpWrite: mtx[it.elem_index] = it.arg_x;
      default: ;
    endcase
  endfunction

  function automatic void check_field(input string name,
                                      input logic signed [DataW-1:0] exp_v,
                                      input logic signed [DataW-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tmb_out_t exp_res;
    if (!rst_ni) begin
      load_identity();
      vertex_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (vertex_q.size() == 0) begin
          $error("result transfer with no vertex pending: %h", out_data_i);
          mismatches++;
        end else begin
          exp_res = vertex_q.pop_front();
          check_field("out_x", exp_res.out_x, out_data_i.out_x);
          check_field("out_y", exp_res.out_y, out_data_i.out_y);
          check_field("out_z", exp_res.out_z, out_data_i.out_z);
          check_field("out_w", exp_res.out_w, out_data_i.out_w);
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_op(in_data_i);
      end
    end
    pending = vertex_q.size();
  end

endmodule

>>> test/transform_matrix_builder_core_test.sv
module transform_matrix_builder_core_test;
  import tmb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandPerPhase = 440;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  tmb_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  tmb_out_t out_data;
  int       send_idle_pct;
  int       recv_stall_pct;
  int       mismatches;
  int       pending;

  transform_matrix_builder_core #(
    .FRAC_BITS(FracBitsDef)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  transform_matrix_builder_core_checker #(
    .FRAC_BITS(FracBitsDef)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic tmb_in_t mk(input tmb_op_e op, input logic signed [31:0] x,
                                 input logic signed [31:0] y, input logic signed [31:0] z,
                                 input logic signed [31:0] w, input logic [3:0] idx);
    tmb_in_t it;
    it.op         = op;
    it.arg_x      = x;
    it.arg_y      = y;
    it.arg_z      = z;
    it.arg_w      = w;
    it.elem_index = idx;
    return it;
  endfunction

  function automatic logic signed [31:0] rand_unit();
    return int'($urandom_range(131072)) - 65536;
  endfunction

  function automatic logic signed [31:0] rand_arg();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return int'($urandom_range(524288)) - 262144;
      5, 6: return rand_unit();
      7, 8: return $urandom;
      default: begin
        case ($urandom_range(5))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 32'sd0;
          3: return -32'sd1;
          4: return 32'sd65536;
          default: return -32'sd65536;
        endcase
      end
    endcase
  endfunction

  function automatic tmb_in_t rand_item();
    tmb_in_t it;
    int      k;
    k  = $urandom_range(99);
    it = mk(OpVertex, rand_arg(), rand_arg(), rand_arg(), rand_arg(),
            4'($urandom_range(15)));
    if (k < 4) begin
      it.op = OpIdentity;
    end else if (k < 14) begin
      it.op = OpTranslate;
    end else if (k < 20) begin
      it.op = OpScale;
    end else if (k < 27) begin
      it.op = OpRotX;
    end else if (k < 34) begin
      it.op = OpRotY;
    end else if (k < 41) begin
      it.op = OpRotZ;
    end else if (k < 52) begin
      it.op = OpWrite;
    end
    if (it.op inside {OpScale, OpRotX, OpRotY, OpRotZ} && $urandom_range(9) < 7) begin
      it.arg_x = rand_unit();
      it.arg_y = rand_unit();
    end
    return it;
  endfunction

  task automatic send_item(input tmb_in_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(mk(OpVertex, 32'sd65536, 32'sd131072, -32'sd196608, 32'sd65536, 4'd3));
    send_item(mk(OpVertex, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                 4'd0));
    send_item(mk(OpWrite, 32'sh7fffffff, $urandom, $urandom, $urandom, 4'd0));
    send_item(mk(OpWrite, 32'sh7fffffff, $urandom, $urandom, $urandom, 4'd1));
    send_item(mk(OpWrite, 32'sh80000000, $urandom, $urandom, $urandom, 4'd15));
    send_item(mk(OpVertex, 32'sh7fffffff, 32'sh7fffffff, 32'sd0, 32'sh7fffffff, 4'd9));
    send_item(mk(OpTranslate, 32'sh80000000, 32'sh7fffffff, -32'sd1, $urandom, 4'd5));
    send_item(mk(OpVertex, -32'sd1, 32'sh80000000, 32'sd65536, -32'sd65536, 4'd2));
    send_item(mk(OpIdentity, $urandom, $urandom, $urandom, $urandom, 4'd15));
    send_item(mk(OpTranslate, 32'sd98304, -32'sd40000, 32'sd7, 32'sd0, 4'd1));
    send_item(mk(OpScale, -32'sd1, $urandom, $urandom, $urandom, 4'd8));
    send_item(mk(OpVertex, 32'sd12345, -32'sd54321, 32'sd65536, 32'sd65536, 4'd0));
    send_item(mk(OpRotX, 32'sd46341, 32'sd46341, $urandom, $urandom, 4'd4));
    send_item(mk(OpRotY, 32'sd56756, -32'sd32768, $urandom, $urandom, 4'd6));
    send_item(mk(OpRotZ, 32'sh80000000, 32'sh7fffffff, $urandom, $urandom, 4'd7));
    send_item(mk(OpVertex, 32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536, 4'd10));
    send_item(mk(OpScale, 32'sh80000000, $urandom, $urandom, $urandom, 4'd11));
    send_item(mk(OpVertex, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                 4'd12));
    send_item(mk(OpIdentity, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 4'd0));
    send_item(mk(OpWrite, $urandom, $urandom, $urandom, $urandom, 4'd14));
    send_item(mk(OpScale, 32'sd0, $urandom, $urandom, $urandom, 4'd13));
    send_item(mk(OpVertex, $urandom, $urandom, $urandom, $urandom, 4'd15));
    send_item(mk(OpIdentity, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 4'd0));

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 51;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 51;
        end
        default: begin
          send_idle_pct  = 20;
          recv_stall_pct = 20;
        end
      endcase
      for (int n = 0; n < RandPerPhase; n++) begin
        send_item(rand_item());
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
